// File: design/wmh_pkg.sv
// shared types, constants and helper functions of the word hash unit
package wmh_pkg;

    localparam int CHAR_W   = 8;
    localparam int LEN_W    = 8;
    localparam int WORD_W   = 32;
    localparam int BUCKET_W = 13;
    localparam int HASH_W   = 10;

    localparam int MAX_WORD_LEN_DEF = 127;

    localparam logic [BUCKET_W-1:0] BUCKET_RESET = 13'd5557;
    localparam logic [WORD_W-1:0]   HASH_MOD     = 32'd1021;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // bit-serial bucket divider
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 6;

    // number of mod 1021 folding lanes
    localparam int N_LANES = 4;

    typedef struct packed {
        logic [LEN_W-1:0]         len;
        logic [WORD_W-1:0]        product;
        logic signed [CHAR_W-1:0] c0;
        logic signed [CHAR_W-1:0] c1;
        logic signed [CHAR_W-1:0] clast;
        logic [WORD_W-1:0]        sum;
    } wmh_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wmh_q_status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_MUL3,
        BK_RUN,
        BK_DONE
    } bk_state_t;

    function automatic logic [WORD_W-1:0] sext8(input logic [CHAR_W-1:0] c);
        return {{(WORD_W-CHAR_W){c[CHAR_W-1]}}, c};
    endfunction

    // one folding step towards x mod 1021, using 1024 = 3 (mod 1021)
    function automatic logic [WORD_W-1:0] fold_step(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] r;
        hi = {10'b0, x[WORD_W-1:10]};
        lo = {22'b0, x[9:0]};
        if (x >= 32'd1024) begin
            r = (hi << 1) + hi + lo;
        end else if (x >= HASH_MOD) begin
            r = x - HASH_MOD;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

// File: design/word_multi_hash.sv
// top level of the per-word multi hash unit
//
// A word streams in one signed character per s_ side transfer, the final
// character flagged by s_last_char. The front part takes one character per
// clock, keeping the first and second characters, the length, a wrapping
// 32-bit sum and a wrapping 32-bit product; characters beyond MAX_WORD_LEN
// are dropped, though a flagged one still closes the word. The finished
// word goes as one record into a two-entry queue, and the back part turns
// it into one m_ side transfer carrying the bucket (|len * product| mod
// bucket_count, zero when bucket_count is zero) and four hashes reduced mod
// 1021. Each word passes the back through queue pop, the multiply states,
// the 32 steps of the bit-serial bucket divider, which bound the time,
// and output load once the output register is empty or m_ready is high.
// The queue lets the front carry on with following words while the back
// works, so input stalls only when two finished words already wait. The
// mod 1021 reductions fold in parallel with the divider and finish first.
// bucket_count is written through cfg_we/cfg_wdata and must only change
// while no word is in flight.
module word_multi_hash #(
    parameter int MAX_WORD_LEN = wmh_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [wmh_pkg::BUCKET_W-1:0]       cfg_wdata,
    // character input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [wmh_pkg::CHAR_W-1:0]  s_ch,
    input  logic                               s_last_char,
    // result output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [wmh_pkg::BUCKET_W-1:0]       m_bucket,
    output logic [wmh_pkg::HASH_W-1:0]         m_hash_pair_sum,
    output logic [wmh_pkg::HASH_W-1:0]         m_hash_ends,
    output logic [wmh_pkg::HASH_W-1:0]         m_hash_char_sum,
    output logic [wmh_pkg::HASH_W-1:0]         m_hash_weighted
);
    import wmh_pkg::*;

    // bucket count register
    logic [BUCKET_W-1:0] bucket_count_reg;

    // front to queue
    logic          q_push;
    wmh_job_t      q_push_job;
    // queue to back
    logic          q_pop;
    wmh_job_t      q_head;
    wmh_q_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_RESET;
        end else if (cfg_we) begin
            bucket_count_reg <= cfg_wdata;
        end
    end

    // character accumulation
    wmh_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_ch        (s_ch),
        .s_last_char (s_last_char),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_job       (q_push_job)
    );

    // finished words waiting for the back part
    wmh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head_job (q_head),
        .status   (q_status)
    );

    // per-word arithmetic and result register
    wmh_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .bucket_count    (bucket_count_reg),
        .q_status        (q_status),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bucket        (m_bucket),
        .m_hash_pair_sum (m_hash_pair_sum),
        .m_hash_ends     (m_hash_ends),
        .m_hash_char_sum (m_hash_char_sum),
        .m_hash_weighted (m_hash_weighted)
    );

endmodule

// File: design/wmh_front.sv
// front part: takes characters in and builds one job record per word
module wmh_front #(
    parameter int MAX_WORD_LEN = wmh_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [wmh_pkg::CHAR_W-1:0]  s_ch,
    input  logic                               s_last_char,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  wmh_pkg::wmh_q_status_t             q_status,
    output logic                               q_push,
    output wmh_pkg::wmh_job_t                  q_job
);
    import wmh_pkg::*;

    logic [LEN_W-1:0]         count_reg,  count_next;
    logic [CHAR_W-1:0]        first_reg,  first_next;
    logic [CHAR_W-1:0]        second_reg, second_next;
    logic [CHAR_W-1:0]        latest_reg, latest_next;
    logic [WORD_W-1:0]        sum_reg,    sum_next;
    logic [WORD_W-1:0]        prod_reg,   prod_next;
    logic                     accept;
    logic                     take;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign take    = count_reg < LEN_W'(MAX_WORD_LEN);
    assign q_push  = accept && s_last_char;

    always_comb begin
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        latest_next = latest_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        // characters beyond the length limit are dropped
        if (take) begin
            if (count_reg == '0) begin
                first_next = s_ch;
            end else if (count_reg == LEN_W'(1)) begin
                second_next = s_ch;
            end
            count_next  = count_reg + LEN_W'(1);
            sum_next    = sum_reg + sext8(s_ch);
            prod_next   = prod_reg * sext8(s_ch);
            latest_next = s_ch;
        end
        q_job.len     = count_next;
        q_job.product = prod_next;
        q_job.c0      = first_next;
        q_job.c1      = second_next;
        q_job.clast   = latest_next;
        q_job.sum     = sum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            latest_reg <= '0;
            sum_reg    <= '0;
            prod_reg   <= WORD_W'(1);
        end else if (accept) begin
            if (s_last_char) begin
                count_reg  <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                latest_reg <= '0;
                sum_reg    <= '0;
                prod_reg   <= WORD_W'(1);
            end else begin
                count_reg  <= count_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                latest_reg <= latest_next;
                sum_reg    <= sum_next;
                prod_reg   <= prod_next;
            end
        end
    end

endmodule

// File: design/wmh_queue.sv
// two-entry job queue between front and back
module wmh_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  wmh_pkg::wmh_job_t      push_job,
    input  logic                   pop,
    output wmh_pkg::wmh_job_t      head_job,
    output wmh_pkg::wmh_q_status_t status
);
    import wmh_pkg::*;

    wmh_job_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign status.empty = cnt_reg == '0;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count beyond depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

// File: design/wmh_back.sv
// back part: products, bit-serial bucket remainder and mod 1021 folding
module wmh_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [wmh_pkg::BUCKET_W-1:0]        bucket_count,
    input  wmh_pkg::wmh_q_status_t              q_status,
    input  wmh_pkg::wmh_job_t                   q_head,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [wmh_pkg::BUCKET_W-1:0]        m_bucket,
    output logic [wmh_pkg::HASH_W-1:0]          m_hash_pair_sum,
    output logic [wmh_pkg::HASH_W-1:0]          m_hash_ends,
    output logic [wmh_pkg::HASH_W-1:0]          m_hash_char_sum,
    output logic [wmh_pkg::HASH_W-1:0]          m_hash_weighted
);
    import wmh_pkg::*;

    bk_state_t              state_reg, state_next;
    wmh_job_t               job_reg;
    logic [WORD_W-1:0]      prod_reg;
    logic [WORD_W-1:0]      pair_reg;
    logic [WORD_W-1:0]      ends_reg;
    logic [WORD_W-1:0]      sq_reg;
    logic [WORD_W-1:0]      w1_reg;
    logic [WORD_W-1:0]      mag;
    logic [WORD_W-1:0]      lane_reg [N_LANES];
    logic [WORD_W-1:0]      dvd_reg;
    logic [BUCKET_W-1:0]    rem_reg;
    logic [BUCKET_W:0]      rem_shift;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic                   div_done;
    logic                   lanes_done;
    logic                   load_out;
    logic                   m_valid_reg;
    logic [BUCKET_W-1:0]    bucket_reg;
    logic [HASH_W-1:0]      hash_reg [N_LANES];
    logic [WORD_W-1:0]      len32;

    assign len32     = {{(WORD_W-LEN_W){1'b0}}, job_reg.len};
    assign mag       = (prod_reg[WORD_W-1] && prod_reg != {1'b1, {(WORD_W-1){1'b0}}}) ?
                       WORD_W'(0) - prod_reg : prod_reg;
    assign rem_shift = {rem_reg, dvd_reg[WORD_W-1]};
    assign div_done  = div_cnt_reg == DIV_CNT_W'(DIV_STEPS);

    always_comb begin
        lanes_done = 1'b1;
        for (int i = 0; i < N_LANES; i++) begin
            if (lane_reg[i] >= HASH_MOD) begin
                lanes_done = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    state_next = BK_MUL1;
                end
            end
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_MUL3;
            BK_MUL3: state_next = BK_RUN;
            BK_RUN: begin
                if (div_done && lanes_done) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_head;
        end
        case (state_reg)
            BK_MUL1: begin
                prod_reg <= job_reg.product * len32;
                pair_reg <= (sext8(job_reg.c0) + sext8(job_reg.c1)) * len32;
                ends_reg <= sext8(job_reg.c0) * sext8(job_reg.clast);
                sq_reg   <= job_reg.sum * job_reg.sum;
            end
            BK_MUL2: begin
                dvd_reg <= mag;
                w1_reg  <= sq_reg * sext8(job_reg.clast);
            end
            BK_MUL3: begin
                lane_reg[0] <= pair_reg;
                lane_reg[1] <= ends_reg;
                lane_reg[2] <= job_reg.sum;
                lane_reg[3] <= w1_reg * (len32 - WORD_W'(1));
                rem_reg     <= '0;
            end
            BK_RUN: begin
                for (int i = 0; i < N_LANES; i++) begin
                    lane_reg[i] <= fold_step(lane_reg[i]);
                end
                if (!div_done) begin
                    dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
                    if (rem_shift >= {1'b0, bucket_count}) begin
                        rem_reg <= BUCKET_W'(rem_shift - {1'b0, bucket_count});
                    end else begin
                        rem_reg <= rem_shift[BUCKET_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            bucket_reg <= (bucket_count == '0) ? '0 : rem_reg;
            for (int i = 0; i < N_LANES; i++) begin
                hash_reg[i] <= lane_reg[i][HASH_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == BK_MUL3) begin
                div_cnt_reg <= '0;
            end else if (state_reg == BK_RUN && !div_done) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_bucket        = bucket_reg;
    assign m_hash_pair_sum = hash_reg[0];
    assign m_hash_ends     = hash_reg[1];
    assign m_hash_char_sum = hash_reg[2];
    assign m_hash_weighted = hash_reg[3];

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RUN |-> div_cnt_reg <= DIV_CNT_W'(DIV_STEPS))
        else $error("divider step count overrun");

    a_hash_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_hash_pair_sum < 10'd1021) && (m_hash_ends < 10'd1021) &&
                        (m_hash_char_sum < 10'd1021) && (m_hash_weighted < 10'd1021))
        else $error("hash value not fully reduced");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_DONE && !m_valid_reg |=> m_valid_reg && state_reg == BK_IDLE)
        else $error("finished word not presented");

endmodule

// File: tb/tb_word_multi_hash.sv
// self-checking testbench for the per-word multi hash unit
`timescale 1ns / 1ps

module tb_word_multi_hash;
    import wmh_pkg::*;

    localparam int MAX_WORD_LEN   = MAX_WORD_LEN_DEF;
    // margin for the back end to finish any word still in flight
    localparam int DRAIN_CYCLES   = 64;
    // clock cycles with no transfer on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic WORD_MID = 1'b0;
    localparam logic WORD_END = 1'b1;

    // one result transfer, field for field
    typedef struct packed {
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   pair_sum;
        logic [HASH_W-1:0]   ends;
        logic [HASH_W-1:0]   char_sum;
        logic [HASH_W-1:0]   weighted;
    } word_hash_t;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        word_hash_t        res;
    } char_row_t;

    localparam int N_ROWS = 23;

    // short hand-built words at the reset bucket count
    char_row_t dir_rows [N_ROWS] = '{
        // single characters: one, zero, both extremes, minus one
        '{8'h01, WORD_END, 1'b1, '{13'd1, 10'd1, 10'd1, 10'd1, 10'd0}},
        '{8'h00, WORD_END, 1'b1, '{13'd0, 10'd0, 10'd0, 10'd0, 10'd0}},
        '{8'h80, WORD_END, 1'b0, '0},
        '{8'h7f, WORD_END, 1'b0, '0},
        '{8'hff, WORD_END, 1'b0, '0},
        // two characters, largest then most negative
        '{8'h7f, WORD_MID, 1'b0, '0},
        '{8'h80, WORD_END, 1'b0, '0},
        // zero character in the middle of a word
        '{8'h80, WORD_MID, 1'b0, '0},
        '{8'h00, WORD_MID, 1'b0, '0},
        '{8'h05, WORD_END, 1'b0, '0},
        // eight characters: len * product lands exactly on the most negative value
        '{8'h80, WORD_MID, 1'b0, '0},
        '{8'h80, WORD_MID, 1'b0, '0},
        '{8'h80, WORD_MID, 1'b0, '0},
        '{8'h80, WORD_MID, 1'b0, '0},
        '{8'h01, WORD_MID, 1'b0, '0},
        '{8'h01, WORD_MID, 1'b0, '0},
        '{8'h01, WORD_MID, 1'b0, '0},
        '{8'h01, WORD_END, 1'b0, '0},
        // plain text word
        '{8'h68, WORD_MID, 1'b0, '0},
        '{8'h69, WORD_MID, 1'b0, '0},
        '{8'h21, WORD_END, 1'b0, '0},
        // alternating bit patterns
        '{8'h55, WORD_MID, 1'b0, '0},
        '{8'haa, WORD_END, 1'b0, '0}
    };

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       cfg_we          = 1'b0;
    logic [BUCKET_W-1:0]        cfg_wdata       = '0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic signed [CHAR_W-1:0]   s_ch            = '0;
    logic                       s_last_char     = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic [BUCKET_W-1:0]        m_bucket;
    logic [HASH_W-1:0]          m_hash_pair_sum;
    logic [HASH_W-1:0]          m_hash_ends;
    logic [HASH_W-1:0]          m_hash_char_sum;
    logic [HASH_W-1:0]          m_hash_weighted;

    word_multi_hash #(
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_last_char    (s_last_char),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bucket       (m_bucket),
        .m_hash_pair_sum(m_hash_pair_sum),
        .m_hash_ends    (m_hash_ends),
        .m_hash_char_sum(m_hash_char_sum),
        .m_hash_weighted(m_hash_weighted)
    );

    always #2 aclk = ~aclk;

    // word state of the predictor, mirroring the block after reset
    logic [LEN_W-1:0]    acc_len    = '0;
    logic [WORD_W-1:0]   acc_first  = '0;
    logic [WORD_W-1:0]   acc_second = '0;
    logic [WORD_W-1:0]   acc_sum    = '0;
    logic [WORD_W-1:0]   acc_prod   = 32'd1;
    logic [WORD_W-1:0]   acc_latest = '0;
    logic [BUCKET_W-1:0] bucket_mod = BUCKET_RESET;

    // hashes still owed by the block, oldest first
    word_hash_t hash_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int chars_sent   = 0;
    int words_sent   = 0;
    int long_words   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    // folds one character into the word; returns 1 with the hashes when the word closes
    function automatic bit absorb_char(input logic [CHAR_W-1:0] ch, input logic last,
                                       output word_hash_t res);
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] prod;
        logic [WORD_W-1:0] mag;
        logic [WORD_W-1:0] pair;
        logic [WORD_W-1:0] ends;
        logic [WORD_W-1:0] weighted;
        logic [WORD_W-1:0] nb;
        c   = {{(WORD_W-CHAR_W){ch[CHAR_W-1]}}, ch};
        res = '0;
        // characters past the length limit are dropped, only their flag counts
        if (32'(acc_len) < MAX_WORD_LEN) begin
            if (acc_len == '0) begin
                acc_first = c;
            end else if (acc_len == LEN_W'(1)) begin
                acc_second = c;
            end
            acc_len    = acc_len + LEN_W'(1);
            acc_sum    = acc_sum + c;
            acc_prod   = acc_prod * c;
            acc_latest = c;
        end
        if (!last) begin
            return 1'b0;
        end
        len  = 32'(acc_len);
        prod = acc_prod * len;
        // the most negative value has no positive twin and stays as it is
        mag  = (prod[WORD_W-1] && prod != 32'h8000_0000) ? (~prod + 32'd1) : prod;
        pair     = (acc_first + acc_second) * len;
        ends     = acc_first * acc_latest;
        weighted = acc_sum * acc_sum * acc_latest * (len - 32'd1);
        nb = 32'(bucket_mod);
        res.bucket   = (nb != '0) ? BUCKET_W'(mag % nb) : '0;
        res.pair_sum = HASH_W'(pair % HASH_MOD);
        res.ends     = HASH_W'(ends % HASH_MOD);
        res.char_sum = HASH_W'(acc_sum % HASH_MOD);
        res.weighted = HASH_W'(weighted % HASH_MOD);
        // word state back to its reset values
        acc_len    = '0;
        acc_first  = '0;
        acc_second = '0;
        acc_sum    = '0;
        acc_prod   = 32'd1;
        acc_latest = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        // lean on the corner values, otherwise any byte
        case ($urandom_range(0, 9))
            0: begin
                return 8'h80;
            end
            1: begin
                return 8'h7f;
            end
            2: begin
                return 8'h00;
            end
            3: begin
                return 8'hff;
            end
            default: begin
                return CHAR_W'($urandom);
            end
        endcase
    endfunction

    // one character transfer, with random hold-off beforehand
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last, input logic typed,
                             input word_hash_t typed_res);
        word_hash_t res;
        bit         done;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_ch        = ch;
        s_last_char = last;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        // transfer taken at this edge, so the predictor moves on
        done = absorb_char(ch, last, res);
        if (done) begin
            hash_q.push_back(typed ? typed_res : res);
            words_sent++;
        end
        chars_sent++;
    endtask

    task automatic send_word(input int n_chars);
        for (int i = 0; i < n_chars; i++) begin
            send_char(rand_char(), (i == n_chars - 1) ? WORD_END : WORD_MID, 1'b0, '0);
        end
    endtask

    // drop valid, wait for every owed result, then let the back end settle
    task automatic await_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (hash_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we     = 1'b0;
        bucket_mod = value;
    endtask

    // one random stretch at a given bucket count and idling mix
    task automatic run_segment(input logic [BUCKET_W-1:0] nb, input int unsigned send_pct,
                               input int unsigned recv_pct, input int n_items,
                               input bit with_long);
        int sent;
        int n;
        await_idle();
        write_bucket_count(nb);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        // one word around the length limit: just under, at and past it
        if (with_long) begin
            n = $urandom_range(MAX_WORD_LEN - 1, MAX_WORD_LEN + 3);
            send_word(n);
            sent += n;
            long_words++;
        end
        while (sent < n_items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_word(n);
            sent += n;
        end
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // compare every result transfer with the oldest owed hash
    always @(posedge aclk) begin : result_check
        word_hash_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (hash_q.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with no word pending, bucket %0d",
                         $time, m_bucket);
            end else begin
                want = hash_q.pop_front();
                check_field("bucket", 32'(want.bucket), 32'(m_bucket));
                check_field("hash_pair_sum", 32'(want.pair_sum), 32'(m_hash_pair_sum));
                check_field("hash_ends", 32'(want.ends), 32'(m_hash_ends));
                check_field("hash_char_sum", 32'(want.char_sum), 32'(m_hash_char_sum));
                check_field("hash_weighted", 32'(want.weighted), 32'(m_hash_weighted));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d hashes still owed",
                     $time, WATCHDOG_LIMIT, hash_q.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed words at the reset bucket count, no idling
        for (int r = 0; r < N_ROWS; r++) begin
            send_char(dir_rows[r].ch, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].res);
        end

        // sender idles less than the receiver
        run_segment(13'd8191, 34, 72, 125, 1'b1);
        run_segment(13'd1, 34, 72, 125, 1'b0);
        // receiver idles less than the sender
        run_segment(13'd0, 72, 34, 125, 1'b0);
        run_segment(BUCKET_W'($urandom_range(2, 8190)), 72, 34, 125, 1'b1);
        // full rate both ways
        run_segment(BUCKET_W'($urandom_range(2, 8190)), 0, 0, 125, 1'b0);
        run_segment(13'd4096, 0, 0, 125, 1'b0);

        await_idle();
        $display("sent %0d characters in %0d words (%0d around the length limit)",
                 chars_sent, words_sent, long_words);
        $display("bucket counts 5557, 8191, 1, 0 and random; %0d results seen, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
